FILE: src/modulated_allpass_delay_macros.svh
// assertion macros for the modulated allpass delay line
`ifndef MODULATED_ALLPASS_DELAY_MACROS_SVH
`define MODULATED_ALLPASS_DELAY_MACROS_SVH

`ifndef SYNTH
`define MAD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define MAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define MAD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MAD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/mad_pkg.sv
// shared types and constants for the modulated allpass delay line
package mad_pkg;

    localparam int DELAY_ADDR_BITS_DEF = 16;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int TAP_W     = 17;

    localparam int DIV_STEPS = 24;
    localparam int DIV_CNT_W = 5;

    localparam logic signed [TAP_W-1:0]    TAP_DIST_RST = 17'sd0;
    localparam logic signed [SAMPLE_W-1:0] AP_COEF_RST  = 16'sd0;
    localparam logic [SAMPLE_W-1:0]        FIXED_DELAY_RST = 16'd1;
    localparam logic signed [SAMPLE_W-1:0] FB_GAIN_RST  = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] BLEND_GAIN_RST = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] FF_GAIN_RST  = 16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOD_DELAY   = 3'd0,
        CFG_FIXED_DELAY = 3'd1,
        CFG_FB_GAIN     = 3'd2,
        CFG_BLEND_GAIN  = 3'd3,
        CFG_FF_GAIN     = 3'd4
    } t_cfg_idx;

endpackage

FILE: src/modulated_allpass_delay.sv
// modulated allpass-interpolated fractional delay line, top level
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------
//  in       | sink      | i_in_valid / o_in_stall    | i_sample_in
//  out      | source    | o_out_valid / i_out_stall  | o_sample_out
//  cfg      | sink      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
//  a new item is taken only after the last has left stages 1 and 2, set by the two
//  delay memory reads per item and the fixed-tap feedback into the next sum
//  a mod_delay write runs the coefficient divider, input stalls meanwhile
//  reset is synchronous; the delay memory is not cleared, a wrap flag and the
//  write pointer mask entries not yet written so they read as zero
//  a stalled result in the output register freezes the whole pipeline once the
//  next item reaches the last stage
module modulated_allpass_delay #(
    parameter int DELAY_ADDR_BITS = mad_pkg::DELAY_ADDR_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [mad_pkg::SAMPLE_W-1:0]     i_sample_in,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [mad_pkg::SAMPLE_W-1:0]     o_sample_out,
    input  logic                                    i_cfg_we,
    input  logic [mad_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [mad_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    `include "modulated_allpass_delay_macros.svh"

    localparam int AW    = DELAY_ADDR_BITS;
    localparam int DEPTH = 1 << AW;
    localparam int EW    = (AW > mad_pkg::TAP_W) ? AW : mad_pkg::TAP_W;
    localparam int SW    = mad_pkg::SAMPLE_W;
    localparam logic [mad_pkg::DIV_CNT_W-1:0] DIV_START = mad_pkg::DIV_CNT_W'(mad_pkg::DIV_STEPS);

    function automatic logic signed [SW-1:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767) begin
            return 16'sh7fff;
        end else if (v < -34'sd32768) begin
            return 16'sh8000;
        end
        return v[SW-1:0];
    endfunction

    // configuration and derived values
    logic signed [mad_pkg::TAP_W-1:0] r_tap_dist;
    logic signed [SW-1:0]             r_ap_coef;
    logic [SW-1:0]                    r_fixed_delay;
    logic signed [SW-1:0]             r_fb_gain;
    logic signed [SW-1:0]             r_blend_gain;
    logic signed [SW-1:0]             r_ff_gain;

    // coefficient divider
    logic [mad_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [23:0]                   r_div_q;
    logic [10:0]                   r_div_rem;
    logic [10:0]                   r_div_den;
    logic                          r_div_neg;
    logic [11:0]                   div_rem_sh;
    logic                          div_bit;
    logic [23:0]                   n_div_q;
    logic [10:0]                   n_div_rem;
    logic                          div_busy;

    // setup for a mod_delay write
    logic        cfg_mod_we;
    logic [7:0]  cfg_frac;
    logic        cfg_low;
    logic [7:0]  cfg_mag;
    logic [9:0]  cfg_den;
    logic        cfg_neg;

    // pipeline control
    logic [7:1] r_v;
    logic       adv;
    logic       in_acc;

    // delay state
    logic [SW-1:0]        r_mem [0:DEPTH-1];
    logic [SW-1:0]        r_rdata;
    logic                 r_rd_zero;
    logic                 r_fwd;
    logic [AW-1:0]        r_wp;
    logic                 r_wrapped;
    logic signed [SW-1:0] r_fixed_tap;
    logic signed [SW-1:0] r_last_in;
    logic signed [SW-1:0] r_last_out;

    // datapath registers
    logic signed [SW-1:0] r_x;
    logic signed [31:0]   r_fb_prod;
    logic signed [SW-1:0] r_sum;
    logic signed [32:0]   r_ap_prod;
    logic signed [SW-1:0] r_ap_in;
    logic signed [31:0]   r_blend_prod;
    logic signed [31:0]   r_ff_prod;
    logic                 r_out_valid;
    logic signed [SW-1:0] r_out;

    // combinational datapath
    logic signed [33:0]   fb_rnd;
    logic signed [SW-1:0] sum;
    logic [AW-1:0]        n_wp;
    logic                 n_wrapped;
    logic [EW-1:0]        dist_ext;
    logic [EW-1:0]        fix_ext;
    logic [AW-1:0]        fixed_addr;
    logic [AW-1:0]        mod_addr;
    logic [AW-1:0]        mem_raddr;
    logic                 mem_we;
    logic                 mem_re;
    logic                 rd_zero;
    logic signed [SW-1:0] fixed_rd;
    logic signed [SW-1:0] ap_in;
    logic signed [16:0]   ap_diff;
    logic signed [33:0]   ap_rnd;
    logic signed [SW-1:0] ap_out;
    logic signed [33:0]   out_acc;
    logic signed [SW-1:0] out_y;

    assign cfg_mod_we = i_cfg_we && (i_cfg_index == mad_pkg::CFG_MOD_DELAY);
    assign cfg_frac = i_cfg_data[7:0];
    assign cfg_low  = ~cfg_frac[7];
    assign cfg_mag  = cfg_low ? cfg_frac : 8'(9'd256 - {1'b0, cfg_frac});
    assign cfg_den  = {cfg_low, ~cfg_low, cfg_frac};
    assign cfg_neg  = cfg_low && (cfg_frac != 8'd0);

    assign div_busy   = (r_div_cnt != '0);
    assign div_rem_sh = {r_div_rem, r_div_q[23]};
    assign div_bit    = (div_rem_sh >= {1'b0, r_div_den});
    assign n_div_rem  = div_bit ? 11'(div_rem_sh - {1'b0, r_div_den}) : div_rem_sh[10:0];
    assign n_div_q    = {r_div_q[22:0], div_bit};

    assign adv        = !(r_v[7] && r_out_valid && i_out_stall);
    assign o_in_stall = !adv || r_v[1] || r_v[2] || div_busy;
    assign in_acc     = i_in_valid && !o_in_stall;

    // stage 2: feedback sum and write address
    assign fb_rnd    = (34'(r_fb_prod) + 34'sd8192) >>> 14;
    assign sum       = sat16(34'(r_x) - fb_rnd);
    assign n_wp      = r_wp + AW'(1);
    assign n_wrapped = r_wrapped || (r_wp == {AW{1'b1}});

    assign dist_ext   = EW'(r_tap_dist);
    assign fix_ext    = EW'(r_fixed_delay);
    assign fixed_addr = n_wp - fix_ext[AW-1:0];
    assign mod_addr   = r_wp - dist_ext[AW-1:0];

    assign mem_we    = adv && r_v[2];
    assign mem_re    = adv && (r_v[2] || r_v[3]);
    assign mem_raddr = r_v[2] ? fixed_addr : mod_addr;
    assign rd_zero   = r_v[2] ? !(n_wrapped || (fixed_addr < n_wp))
                              : !(r_wrapped || (mod_addr < r_wp));

    // stage 3 and 4: tap reads
    assign fixed_rd = r_fwd ? r_sum : (r_rd_zero ? '0 : r_rdata);
    assign ap_in    = r_rd_zero ? '0 : r_rdata;
    assign ap_diff  = 17'(ap_in) - 17'(r_last_out);

    // stage 5: allpass output
    assign ap_rnd = (34'(r_ap_prod) + 34'sd16384) >>> 15;
    assign ap_out = sat16(ap_rnd + 34'(r_last_in));

    // stage 7: output mix
    assign out_acc = (34'(r_blend_prod) + 34'(r_ff_prod) + 34'sd8192) >>> 14;
    assign out_y   = sat16(out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_dist    <= mad_pkg::TAP_DIST_RST;
            r_ap_coef     <= mad_pkg::AP_COEF_RST;
            r_fixed_delay <= mad_pkg::FIXED_DELAY_RST;
            r_fb_gain     <= mad_pkg::FB_GAIN_RST;
            r_blend_gain  <= mad_pkg::BLEND_GAIN_RST;
            r_ff_gain     <= mad_pkg::FF_GAIN_RST;
            r_div_cnt     <= '0;
        end else begin
            if (div_busy) begin
                r_div_cnt <= r_div_cnt - mad_pkg::DIV_CNT_W'(1);
                if (r_div_cnt == mad_pkg::DIV_CNT_W'(1)) begin
                    r_ap_coef <= r_div_neg ? -$signed(n_div_q[SW-1:0])
                                           : $signed(n_div_q[SW-1:0]);
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mad_pkg::CFG_MOD_DELAY: begin
                        r_tap_dist <= {1'b0, i_cfg_data[23:8]} - {16'd0, cfg_low};
                        r_div_cnt  <= DIV_START;
                    end
                    mad_pkg::CFG_FIXED_DELAY: r_fixed_delay <= i_cfg_data[SW-1:0];
                    mad_pkg::CFG_FB_GAIN:     r_fb_gain     <= i_cfg_data[SW-1:0];
                    mad_pkg::CFG_BLEND_GAIN:  r_blend_gain  <= i_cfg_data[SW-1:0];
                    mad_pkg::CFG_FF_GAIN:     r_ff_gain     <= i_cfg_data[SW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (cfg_mod_we) begin
            r_div_q   <= {cfg_mag, 6'd0, cfg_den};
            r_div_rem <= '0;
            r_div_den <= {cfg_den, 1'b0};
            r_div_neg <= cfg_neg;
        end else if (div_busy) begin
            r_div_q   <= n_div_q;
            r_div_rem <= n_div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_fixed_tap <= '0;
            r_last_in   <= '0;
            r_last_out  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_v <= {r_v[6:1], in_acc};
                if (r_v[2]) begin
                    r_wp      <= n_wp;
                    r_wrapped <= n_wrapped;
                end
                if (r_v[3]) begin
                    r_fixed_tap <= fixed_rd;
                end
                if (r_v[5]) begin
                    r_last_in  <= r_ap_in;
                    r_last_out <= ap_out;
                end
            end
            if (adv && r_v[7]) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // delay memory, one write and one read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= sum;
        end
        if (mem_re) begin
            r_rdata   <= r_mem[mem_raddr];
            r_rd_zero <= rd_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= i_sample_in;
        end
        if (adv) begin
            if (r_v[1]) begin
                r_fb_prod <= r_fb_gain * r_fixed_tap;
            end
            if (r_v[2]) begin
                r_sum <= sum;
                r_fwd <= (fixed_addr == r_wp);
            end
            if (r_v[4]) begin
                r_ap_prod    <= r_ap_coef * ap_diff;
                r_ap_in      <= ap_in;
                r_blend_prod <= r_blend_gain * r_sum;
            end
            if (r_v[6]) begin
                r_ff_prod <= r_ff_gain * r_last_out;
            end
            if (r_v[7]) begin
                r_out <= out_y;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    // items stay at least three stages apart
    `MAD_ASSERT_IMPL(a_item_spacing, i_clk, i_rst_n, r_v[3:1] != 3'b000, $onehot0(r_v[3:1]))
    // a blocked last stage keeps its item
    `MAD_ASSERT_NEXT(a_last_hold, i_clk, i_rst_n, r_v[7] && !adv, r_v[7])
    // a delay write restarts the coefficient divider
    `MAD_ASSERT_NEXT(a_div_start, i_clk, i_rst_n, cfg_mod_we, r_div_cnt == DIV_START)

endmodule
